// File: design/vha_pkg.sv
package vha_pkg;

   // default sizes
   localparam int DEF_COORD_BITS   = 24;
   localparam int DEF_CORDIC_STEPS = 16;

   // coordinates are scaled up to this many bits before rotation
   localparam int SCALED_BITS = 56;
   // datapath width: scaled value, CORDIC gain, sqrt(2) and sign
   localparam int DW = 60;
   // angle accumulator, degrees Q.16
   localparam int AW = 27;
   // angle after rounding, degrees Q9.7 with headroom
   localparam int QW = 18;

   localparam logic signed [AW-1:0] DEG180_Q16 = 27'sd11796480;
   localparam logic signed [QW-1:0] DEG90_Q7   = 18'sd11520;
   localparam logic signed [QW-1:0] DEG180_Q7  = 18'sd23040;
   localparam logic signed [QW-1:0] DEG360_Q7  = 18'sd46080;
   localparam logic signed [AW-1:0] ROUND_HALF = 27'sd256;

   // 1/K in Q.30
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

   typedef enum logic [1:0] {
      FUNC_YAW      = 2'd0,
      FUNC_PITCH    = 2'd1,
      FUNC_ABS_DIFF = 2'd2,
      FUNC_REL_YAW  = 2'd3
   } func_type;

   // side information carried alongside each item through the chain
   typedef struct packed {
      func_type                func;
      logic signed [QW-1:0]    ref_yaw;
      logic                    xy_zero;
      logic                    y_zero;
      logic                    x_neg;
      logic                    z_zero;
      logic                    z_neg;
      logic                    rc_zero;
      logic signed [DW-1:0]    zz;
      logic signed [AW-1:0]    a1;
   } meta_type;

   // atan(2^-i) in degrees, Q.16
   function automatic logic signed [AW-1:0] atan_q16(input int idx);
      logic signed [AW-1:0] r;
      begin
         case (idx)
            0:  r = 27'sd2949120;
            1:  r = 27'sd1740967;
            2:  r = 27'sd919879;
            3:  r = 27'sd466945;
            4:  r = 27'sd234379;
            5:  r = 27'sd117304;
            6:  r = 27'sd58666;
            7:  r = 27'sd29335;
            8:  r = 27'sd14668;
            9:  r = 27'sd7334;
            10: r = 27'sd3667;
            11: r = 27'sd1833;
            12: r = 27'sd917;
            13: r = 27'sd458;
            14: r = 27'sd229;
            15: r = 27'sd115;
            16: r = 27'sd57;
            17: r = 27'sd29;
            18: r = 27'sd14;
            19: r = 27'sd7;
            20: r = 27'sd4;
            21: r = 27'sd2;
            22: r = 27'sd1;
            default: r = 27'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

// File: design/vha_cell.sv
module vha_cell
   import vha_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] in_x,
   input  logic signed [DW-1:0] in_y,
   input  logic signed [AW-1:0] in_z,
   input  meta_type             in_meta,
   output logic                 out_valid,
   output logic signed [DW-1:0] out_x,
   output logic signed [DW-1:0] out_y,
   output logic signed [AW-1:0] out_z,
   output meta_type             out_meta
);

   logic                 valid_ff;
   logic signed [DW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] z_ff, z_in;
   meta_type             meta_ff;
   logic signed [DW-1:0] dx, dy;

   // one vectoring rotation: drive y toward zero
   always_comb begin
      dx = in_y >>> STEP;
      dy = in_x >>> STEP;
      if (in_y > 0) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + atan_q16(STEP);
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - atan_q16(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_meta  = meta_ff;

endmodule

// File: design/vha_gain.sv
module vha_gain
   import vha_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] in_mag,
   input  logic signed [AW-1:0] in_angle,
   input  meta_type             in_meta,
   output logic                 out_valid,
   output logic signed [DW-1:0] out_x,
   output logic signed [DW-1:0] out_y,
   output logic signed [AW-1:0] out_z,
   output meta_type             out_meta
);

   localparam int HALF = 29;
   localparam int PW   = 59;
   localparam int SW   = PW + HALF + 1;

   logic [1:0]           valid_ff;
   logic [PW-1:0]        p_lo_ff, p_lo_in, p_hi_ff, p_hi_in;
   meta_type             meta1_ff, meta1_in, meta2_ff, meta2_in;
   logic [DW-1:0]        rc_ff, rc_in;
   logic [SW-1:0]        sum;

   // first cycle: two partial products of magnitude times 1/K
   always_comb begin
      p_lo_in = PW'(in_mag[HALF-1:0]) * PW'(INV_GAIN_Q30);
      p_hi_in = PW'(in_mag[2*HALF-1:HALF]) * PW'(INV_GAIN_Q30);
      meta1_in    = in_meta;
      meta1_in.a1 = in_angle;
   end

   // second cycle: combine and drop the Q.30 fraction
   always_comb begin
      sum   = {1'b0, p_hi_ff, {HALF{1'b0}}} + SW'(p_lo_ff);
      rc_in = DW'(sum[SW-1:30]);
      meta2_in         = meta1_ff;
      meta2_in.rc_zero = (rc_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_lo_ff  <= p_lo_in;
         p_hi_ff  <= p_hi_in;
         meta1_ff <= meta1_in;
         rc_ff    <= rc_in;
         meta2_ff <= meta2_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_x     = signed'(rc_ff);
   assign out_y     = meta2_ff.zz;
   assign out_z     = '0;
   assign out_meta  = meta2_ff;

endmodule

// File: design/vha_finish.sv
module vha_finish
   import vha_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [AW-1:0] in_angle,
   input  meta_type             in_meta,
   output logic                 out_valid,
   output logic signed [15:0]   out_angle
);

   logic [1:0]           valid_ff;
   logic signed [QW-1:0] q_ff, q_in, r_in;
   func_type             func_ff;
   logic signed [QW-1:0] ref_ff;
   logic signed [15:0]   angle_ff;
   logic signed [QW-1:0] yq, pq, d;
   logic signed [AW-1:0] yr, pr;

   // yaw or pitch, rounded to Q9.7, special cases applied
   always_comb begin
      yr = (in_meta.a1 + ROUND_HALF) >>> 9;
      pr = (in_angle + ROUND_HALF) >>> 9;
      yq = QW'(yr);
      if (yq <= -DEG180_Q7) begin
         yq = yq + DEG360_Q7;
      end else if (yq > DEG180_Q7) begin
         yq = yq - DEG360_Q7;
      end
      if (in_meta.xy_zero) begin
         yq = DEG90_Q7;
      end else if (in_meta.y_zero) begin
         yq = in_meta.x_neg ? DEG180_Q7 : '0;
      end

      pq = -QW'(pr);
      if (pq > DEG90_Q7) begin
         pq = DEG90_Q7;
      end else if (pq < -DEG90_Q7) begin
         pq = -DEG90_Q7;
      end
      if (in_meta.z_zero) begin
         pq = '0;
      end else if (in_meta.rc_zero) begin
         pq = in_meta.z_neg ? DEG90_Q7 : -DEG90_Q7;
      end

      q_in = (in_meta.func == FUNC_PITCH) ? pq : yq;
   end

   // combine with the reference yaw
   always_comb begin
      d    = q_ff - ref_ff;
      r_in = q_ff;
      case (func_ff)
         FUNC_ABS_DIFF: begin
            r_in = (q_ff > ref_ff) ? d : -d;
            if (r_in > DEG180_Q7) begin
               r_in = DEG360_Q7 - r_in;
            end
         end
         FUNC_REL_YAW: begin
            r_in = d;
            if (d > DEG180_Q7) begin
               r_in = d - DEG360_Q7;
            end else if (d < -DEG180_Q7) begin
               r_in = d + DEG360_Q7;
            end
         end
         default: r_in = q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff     <= q_in;
         func_ff  <= in_meta.func;
         ref_ff   <= in_meta.ref_yaw;
         angle_ff <= r_in[15:0];
      end
   end

   assign out_valid = valid_ff[1];
   assign out_angle = angle_ff;

endmodule

// File: design/vector_heading_angles_core.sv
// Channel   Dir  Handshake           Payload
// req_      in   req_tvalid/tready   tuser: func; tdata: vec_x, vec_y, vec_z, ref_yaw
// rsp_      out  rsp_tvalid/tready   tdata: angle
//
// One item enters per cycle while rsp_ is not stalled; the chain is one entry
// stage, two rows of CORDIC cells, two for the 1/K product, two to finish.
// Synchronous reset clears all valid bits; data registers are not reset.
// A result held on rsp_ with rsp_tready low freezes the whole chain and
// drops req_tready; otherwise every cell moves its item one place each cycle.
module vector_heading_angles_core
   import vha_pkg::*;
#(
   parameter int COORD_BITS   = DEF_COORD_BITS,
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
   localparam int IN_BITS     = 3 * COORD_BITS + 16,
   localparam int IN_W        = ((IN_BITS + 7) / 8) * 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // vec_x, vec_y, vec_z, ref_yaw, zero fill (low bit up)
   input  logic [IN_W-1:0] req_tdata,
   // func
   input  logic [1:0]      req_tuser,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // angle
   output logic [15:0]     rsp_tdata
);

   localparam int GUARD = SCALED_BITS - COORD_BITS;

   logic en;

   // entry stage signals
   logic signed [COORD_BITS-1:0] vx, vy, vz;
   logic signed [15:0]           ref_raw;
   logic signed [DW-1:0]         sx, sy, sz;
   logic signed [DW-1:0]         x0_ff, x0_in, y0_ff, y0_in;
   logic signed [AW-1:0]         z0_ff, z0_in;
   meta_type                     m0_ff, m0_in;
   logic                         v0_ff;

   // chain wiring
   logic                 c1_v [CORDIC_STEPS+1];
   logic signed [DW-1:0] c1_x [CORDIC_STEPS+1];
   logic signed [DW-1:0] c1_y [CORDIC_STEPS+1];
   logic signed [AW-1:0] c1_z [CORDIC_STEPS+1];
   meta_type             c1_m [CORDIC_STEPS+1];
   logic                 c2_v [CORDIC_STEPS+1];
   logic signed [DW-1:0] c2_x [CORDIC_STEPS+1];
   logic signed [DW-1:0] c2_y [CORDIC_STEPS+1];
   logic signed [AW-1:0] c2_z [CORDIC_STEPS+1];
   meta_type             c2_m [CORDIC_STEPS+1];

   logic signed [15:0] angle;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // unpack, scale up, fold the left half plane
   always_comb begin
      vx      = req_tdata[COORD_BITS-1:0];
      vy      = req_tdata[2*COORD_BITS-1:COORD_BITS];
      vz      = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
      ref_raw = req_tdata[3*COORD_BITS+15:3*COORD_BITS];
      sx = DW'(vx) <<< GUARD;
      sy = DW'(vy) <<< GUARD;
      sz = DW'(vz) <<< GUARD;

      m0_in         = '0;
      m0_in.func    = func_type'(req_tuser);
      m0_in.xy_zero = (vx == '0) && (vy == '0);
      m0_in.y_zero  = (vy == '0);
      m0_in.x_neg   = vx[COORD_BITS-1];
      m0_in.z_zero  = (vz == '0);
      m0_in.z_neg   = vz[COORD_BITS-1];
      m0_in.zz      = sz;
      if (QW'(ref_raw) > DEG180_Q7) begin
         m0_in.ref_yaw = DEG180_Q7;
      end else if (QW'(ref_raw) < -DEG180_Q7) begin
         m0_in.ref_yaw = -DEG180_Q7;
      end else begin
         m0_in.ref_yaw = QW'(ref_raw);
      end

      if (vx[COORD_BITS-1]) begin
         x0_in = -sx;
         y0_in = -sy;
         z0_in = vy[COORD_BITS-1] ? -DEG180_Q16 : DEG180_Q16;
      end else begin
         x0_in = sx;
         y0_in = sy;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         z0_ff <= z0_in;
         m0_ff <= m0_in;
      end
   end

   assign c1_v[0] = v0_ff;
   assign c1_x[0] = x0_ff;
   assign c1_y[0] = y0_ff;
   assign c1_z[0] = z0_ff;
   assign c1_m[0] = m0_ff;

   // first row: angle of (x, y) and its magnitude
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_row1
      vha_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (c1_v[i]),
         .in_x     (c1_x[i]),
         .in_y     (c1_y[i]),
         .in_z     (c1_z[i]),
         .in_meta  (c1_m[i]),
         .out_valid(c1_v[i+1]),
         .out_x    (c1_x[i+1]),
         .out_y    (c1_y[i+1]),
         .out_z    (c1_z[i+1]),
         .out_meta (c1_m[i+1])
      );
   end

   // remove the CORDIC gain from the magnitude
   vha_gain u_gain (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c1_v[CORDIC_STEPS]),
      .in_mag   (c1_x[CORDIC_STEPS]),
      .in_angle (c1_z[CORDIC_STEPS]),
      .in_meta  (c1_m[CORDIC_STEPS]),
      .out_valid(c2_v[0]),
      .out_x    (c2_x[0]),
      .out_y    (c2_y[0]),
      .out_z    (c2_z[0]),
      .out_meta (c2_m[0])
   );

   // second row: elevation of (rc, z)
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_row2
      vha_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (c2_v[i]),
         .in_x     (c2_x[i]),
         .in_y     (c2_y[i]),
         .in_z     (c2_z[i]),
         .in_meta  (c2_m[i]),
         .out_valid(c2_v[i+1]),
         .out_x    (c2_x[i+1]),
         .out_y    (c2_y[i+1]),
         .out_z    (c2_z[i+1]),
         .out_meta (c2_m[i+1])
      );
   end

   vha_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c2_v[CORDIC_STEPS]),
      .in_angle (c2_z[CORDIC_STEPS]),
      .in_meta  (c2_m[CORDIC_STEPS]),
      .out_valid(rsp_tvalid),
      .out_angle(angle)
   );

   assign rsp_tdata = angle;

`ifndef NO_ASSERTIONS
   // a stalled result holds off new items
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // every result lies within plus or minus 180 degrees
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= 16'sd23040 &&
                      $signed(rsp_tdata) >= -16'sd23040))
      else $error("angle out of range");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb
   import vha_pkg::*;
;

   localparam int CB      = DEF_COORD_BITS;
   localparam int STEPS   = DEF_CORDIC_STEPS;
   localparam int IN_W    = (((3 * CB + 16) + 7) / 8) * 8;
   localparam int LATENCY = 2 * STEPS + 5;
   localparam int GSHIFT  = SCALED_BITS - CB;
   localparam longint LIMIT = 400000;

   localparam longint Q16_180 = 11796480;
   localparam longint Q7_90   = 11520;
   localparam longint Q7_180  = 23040;
   localparam longint Q7_360  = 46080;
   localparam longint GAIN_INV = 652032874;

   typedef struct {
      func_type func;
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
      logic signed [15:0] ref_yaw;
      bit known;
      logic signed [15:0] angle;
   } vec_item_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [15:0] rsp_tdata;

   logic signed [15:0] angle_q[$];
   vec_item_type directed[$];
   int errors = 0;
   longint cycles = 0;
   bit quiet_phase = 0;

   vector_heading_angles_core dut (.*);

   always #2 clock = ~clock;

   // atan(2^-i) in degrees, Q.16
   function automatic longint atan_deg(int i);
      longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return t[i];
   endfunction

   // vectoring rotation; returns angle, leaves magnitude in mx
   function automatic longint rotate_to_axis(inout longint mx, inout longint my);
      longint acc, dx, dy;
      acc = 0;
      for (int i = 0; i < STEPS && i < 24; i++) begin
         dx = my >>> i;
         dy = mx >>> i;
         if (my > 0) begin
            mx += dx; my -= dy; acc += atan_deg(i);
         end else begin
            mx -= dx; my += dy; acc -= atan_deg(i);
         end
      end
      return acc;
   endfunction

   function automatic longint heading_q16(longint x, longint y, output longint mag);
      longint base;
      base = 0;
      if (x < 0) begin
         base = (y >= 0) ? Q16_180 : -Q16_180;
         x = -x;
         y = -y;
      end
      base += rotate_to_axis(x, y);
      mag = x;
      return base;
   endfunction

   function automatic longint to_q7(longint a);
      return (a + 256) >>> 9;
   endfunction

   function automatic longint yaw_of(longint x, longint y);
      longint mag, q;
      if (x == 0 && y == 0) return Q7_90;
      if (y == 0) return (x > 0) ? 0 : Q7_180;
      q = to_q7(heading_q16(x <<< GSHIFT, y <<< GSHIFT, mag));
      if (q <= -Q7_180) q += Q7_360;
      else if (q > Q7_180) q -= Q7_360;
      return q;
   endfunction

   function automatic longint pitch_of(longint x, longint y, longint z);
      longint mag, rc, zz, q, dummy;
      if (z == 0) return 0;
      dummy = heading_q16(x <<< GSHIFT, y <<< GSHIFT, mag);
      rc = (mag >> 30) * GAIN_INV + (((mag & ((64'sd1 <<< 30) - 1)) * GAIN_INV) >> 30);
      if (rc == 0) return (z > 0) ? -Q7_90 : Q7_90;
      zz = z <<< GSHIFT;
      q = -to_q7(rotate_to_axis(rc, zz));
      if (q > Q7_90) q = Q7_90;
      if (q < -Q7_90) q = -Q7_90;
      return q;
   endfunction

   function automatic logic signed [15:0] predict_angle(vec_item_type it);
      longint r, yaw, rf;
      rf = it.ref_yaw;
      if (rf > Q7_180) rf = Q7_180;
      if (rf < -Q7_180) rf = -Q7_180;
      if (it.func == FUNC_PITCH) begin
         r = pitch_of(it.x, it.y, it.z);
      end else begin
         yaw = yaw_of(it.x, it.y);
         case (it.func)
            FUNC_YAW: r = yaw;
            FUNC_ABS_DIFF: begin
               r = (yaw > rf) ? yaw - rf : rf - yaw;
               if (r > Q7_180) r = Q7_360 - r;
            end
            default: begin
               r = yaw - rf;
               if (r > Q7_180) r -= Q7_360;
               else if (r < -Q7_180) r += Q7_360;
            end
         endcase
      end
      return r[15:0];
   endfunction

   function automatic vec_item_type mk(func_type f, longint x, longint y, longint z,
                                       longint rf, bit known = 0, longint ang = 0);
      vec_item_type it;
      it.func = f; it.x = CB'(x); it.y = CB'(y); it.z = CB'(z); it.ref_yaw = 16'(rf);
      it.known = known; it.angle = 16'(ang);
      return it;
   endfunction

   function automatic logic signed [CB-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
         1: return CB'($signed($urandom_range(0, 15)) - 8);
         2: return 0;
         default: return CB'($urandom);
      endcase
   endfunction

   // cycle counter and watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("vector_heading_angles_core test failed");
         $finish;
      end
   end

   // result side: random stalls, check against oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (angle_q.size() == 0) begin
               $display("%0t: unexpected angle, actual %0d", $time, $signed(rsp_tdata));
               errors++;
            end else begin
               if ($signed(rsp_tdata) !== angle_q[0]) begin
                  $display("%0t: angle mismatch, expected %0d actual %0d",
                           $time, angle_q[0], $signed(rsp_tdata));
                  errors++;
               end
               void'(angle_q.pop_front());
            end
         end
         rsp_tready <= quiet_phase || ($urandom_range(0, 99) >= 14);
      end
   end

   task automatic send_item(vec_item_type it);
      while (!quiet_phase && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= it.func;
      req_tdata <= IN_W'({it.ref_yaw, it.z, it.y, it.x});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      angle_q.push_back(it.known ? it.angle : predict_angle(it));
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (angle_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      vec_item_type it;
      longint mx, mn;
      mx = (64'sd1 <<< (CB - 1)) - 1;
      mn = -(64'sd1 <<< (CB - 1));
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed table
      directed.push_back(mk(FUNC_YAW, 0, 0, 0, 0, 1, Q7_90));
      directed.push_back(mk(FUNC_YAW, 5, 0, 0, 0, 1, 0));
      directed.push_back(mk(FUNC_YAW, -5, 0, 0, 0, 1, Q7_180));
      directed.push_back(mk(FUNC_YAW, mx, mx, 0, 0));
      directed.push_back(mk(FUNC_YAW, mn, -1, 0, 0));
      directed.push_back(mk(FUNC_YAW, mn, 1, 0, 0));
      directed.push_back(mk(FUNC_YAW, 0, mn, 0, 0));
      directed.push_back(mk(FUNC_PITCH, 0, 0, 0, 0, 1, 0));
      directed.push_back(mk(FUNC_PITCH, 7, 3, 0, 0, 1, 0));
      directed.push_back(mk(FUNC_PITCH, 0, 0, 9, 0, 1, -Q7_90));
      directed.push_back(mk(FUNC_PITCH, 0, 0, mn, 0, 1, Q7_90));
      directed.push_back(mk(FUNC_PITCH, mx, mn, mx, 0));
      directed.push_back(mk(FUNC_PITCH, 1, 0, mn, 0));
      directed.push_back(mk(FUNC_ABS_DIFF, 0, 0, 0, -Q7_90, 1, Q7_180));
      directed.push_back(mk(FUNC_ABS_DIFF, -5, 0, 0, -Q7_180, 1, 0));
      directed.push_back(mk(FUNC_ABS_DIFF, 5, 0, 0, 16'sh7fff, 1, Q7_180));
      directed.push_back(mk(FUNC_ABS_DIFF, mx, 3, 0, 16'sh8000));
      directed.push_back(mk(FUNC_REL_YAW, -5, 0, 0, -Q7_180, 1, 0));
      directed.push_back(mk(FUNC_REL_YAW, 5, 0, 0, Q7_180, 1, -Q7_180));
      directed.push_back(mk(FUNC_REL_YAW, 0, 0, 0, -Q7_180, 1, -Q7_90));
      directed.push_back(mk(FUNC_REL_YAW, mn, -7, mx, 16'sh7fff));
      directed.push_back(mk(FUNC_REL_YAW, 3, mn, 0, 16'sh8000));
      foreach (directed[i]) send_item(directed[i]);

      // hold off until the pipeline has emptied
      wait_drained();

      for (int n = 0; n < 700; n++) begin
         quiet_phase = (n >= 250 && n < 380);
         it.func = func_type'($urandom_range(0, 3));
         it.x = rand_coord();
         it.y = rand_coord();
         it.z = rand_coord();
         if ($urandom_range(0, 9) == 0) it.ref_yaw = 16'($urandom);
         else it.ref_yaw = $signed(16'($urandom_range(0, 2 * Q7_180))) - 16'sd23040;
         it.known = 0;
         it.angle = 0;
         send_item(it);
      end
      quiet_phase = 0;
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("vector_heading_angles_core test passed");
      else
         $display("vector_heading_angles_core test failed");
      $finish;
   end
endmodule
